// ===== design/cts_pkg.sv =====
package cts_pkg;

  typedef enum logic [2:0] {
    CMD_TICK   = 3'd0,
    CMD_MODE   = 3'd1,
    CMD_SELECT = 3'd2,
    CMD_UP     = 3'd3,
    CMD_DOWN   = 3'd4,
    CMD_SAMPLE = 3'd5
  } cmd_e;

  localparam logic [2:0] FIELD_YEAR   = 3'd0;
  localparam logic [2:0] FIELD_MONTH  = 3'd1;
  localparam logic [2:0] FIELD_DAY    = 3'd2;
  localparam logic [2:0] FIELD_HOUR   = 3'd3;
  localparam logic [2:0] FIELD_MINUTE = 3'd4;
  localparam logic [2:0] FIELD_SECOND = 3'd5;

  localparam logic [15:0] BLINK_TICKS_RESET = 16'd500;

  typedef struct packed {
    logic [2:0] command;
    logic [6:0] rtc_year;
    logic [3:0] rtc_month;
    logic [4:0] rtc_day;
    logic [4:0] rtc_hour;
    logic [5:0] rtc_minute;
    logic [5:0] rtc_second;
  } req_t;

  typedef struct packed {
    logic       in_set_mode;
    logic [2:0] selected_field;
    logic       blank_selected;
    logic [6:0] year_out;
    logic [3:0] month_out;
    logic [4:0] day_out;
    logic [4:0] hour_out;
    logic [5:0] minute_out;
    logic [5:0] second_out;
    logic       commit;
  } rsp_t;

  typedef logic [15:0] cfg_t;

  // Days in the given month; February has 29 days when the year is a multiple of four.
  function automatic logic [4:0] day_limit(logic [3:0] month, logic [1:0] year_lo);
    logic [4:0] lim;
    case (month) inside
      4'd4, 4'd6, 4'd9, 4'd11: lim = 5'd30;
      4'd2:                    lim = (year_lo == 2'd0) ? 5'd29 : 5'd28;
      default:                 lim = 5'd31;
    endcase
    return lim;
  endfunction

endpackage

// ===== design/cts_chan_if.sv =====
interface cts_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== design/clock_time_set_editor_core.sv =====
// Key-driven editor for a six-field clock: year, month, day, hour, minute and second.
// Requests arrive on req_i and carry a command (tick, mode key, select, up, down or
// RTC sample) together with a sampled time that only the RTC sample command uses.
// Every request produces exactly one response on rsp_o, which reports the mode, the
// selected field, the blank flag for blinking, all six fields and a commit pulse
// that marks the mode key leaving set mode.
// The cfg_i channel writes the blink period in ticks and is always ready; the user
// writes it only while no request is in flight, which the block does not enforce.
// A request is decoded and applied to the state registers in the cycle it is
// accepted, and its response sits in the output register from the next cycle on;
// one request is taken per cycle while the receiver takes each response.
// The output register is the only buffer: while a response waits on a stalled
// receiver, req_i.ready is low, and it goes high again in the cycle the response
// is taken, so a new request can be accepted in that same cycle.
// Reset puts the block in show mode with year selected, blink phase and tick
// count at zero, the date at year 0, January 1, 00:00:00, and the blink period at 500.
module clock_time_set_editor_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  cts_chan_if.sink   req_i,
  cts_chan_if.source rsp_o,
  cts_chan_if.sink   cfg_i
);

  logic        set_mode_q, set_mode_d;
  logic [2:0]  field_sel_q, field_sel_d;
  logic        blink_q, blink_d;
  logic [15:0] tick_q, tick_d;
  logic [15:0] blink_ticks_q;
  logic [6:0]  year_q, year_d;
  logic [3:0]  month_q, month_d;
  logic [4:0]  day_q, day_d;
  logic [4:0]  hour_q, hour_d;
  logic [5:0]  minute_q, minute_d;
  logic [5:0]  second_q, second_d;
  logic        commit_d;

  cts_pkg::rsp_t rsp_q, rsp_d;
  logic          rsp_valid_q;
  logic          req_accept;

  logic [5:0]  hit;
  logic [15:0] tick_inc;

  logic [7:0] up_year;
  logic [4:0] up_month;
  logic [5:0] up_day;
  logic [5:0] up_hour;
  logic [6:0] up_minute, up_second;
  logic [6:0] up_year_n;
  logic [3:0] up_month_n;
  logic [4:0] up_lim, up_day_n, up_hour_n;
  logic [5:0] up_minute_n, up_second_n;

  logic signed [8:0] dn_year, dn_month, dn_day, dn_hour, dn_minute, dn_second;
  logic [6:0] dn_year_n;
  logic [3:0] dn_month_n;
  logic [4:0] dn_lim, dn_day_n, dn_hour_n;
  logic [5:0] dn_minute_n, dn_second_n;

  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign req_accept  = req_i.valid && req_i.ready;
  assign cfg_i.ready = 1'b1;

  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data  = rsp_q;

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      hit[i] = (field_sel_q == 3'(i));
    end
  end

  assign tick_inc = tick_q + 16'd1;

  // Up step: the selected field goes up by one, then every field wraps past its top.
  always_comb begin
    up_year   = {1'b0, year_q} + {7'd0, hit[cts_pkg::FIELD_YEAR]};
    up_month  = {1'b0, month_q} + {4'd0, hit[cts_pkg::FIELD_MONTH]};
    up_day    = {1'b0, day_q} + {5'd0, hit[cts_pkg::FIELD_DAY]};
    up_hour   = {1'b0, hour_q} + {5'd0, hit[cts_pkg::FIELD_HOUR]};
    up_minute = {1'b0, minute_q} + {6'd0, hit[cts_pkg::FIELD_MINUTE]};
    up_second = {1'b0, second_q} + {6'd0, hit[cts_pkg::FIELD_SECOND]};

    up_year_n   = (up_year > 8'd99) ? 7'd0 : up_year[6:0];
    up_month_n  = (up_month > 5'd12) ? 4'd1 : up_month[3:0];
    up_lim      = cts_pkg::day_limit(up_month_n, up_year_n[1:0]);
    up_day_n    = (up_day > {1'b0, up_lim}) ? 5'd1 : up_day[4:0];
    up_hour_n   = (up_hour > 6'd23) ? 5'd0 : up_hour[4:0];
    up_minute_n = (up_minute > 7'd59) ? 6'd0 : up_minute[5:0];
    up_second_n = (up_second > 7'd59) ? 6'd0 : up_second[5:0];
  end

  // Down step: selected field minus one; low fields wrap, an over-limit day goes to 1.
  always_comb begin
    dn_year   = $signed({2'b00, year_q}) - $signed({8'd0, hit[cts_pkg::FIELD_YEAR]});
    dn_month  = $signed({5'd0, month_q}) - $signed({8'd0, hit[cts_pkg::FIELD_MONTH]});
    dn_day    = $signed({4'd0, day_q}) - $signed({8'd0, hit[cts_pkg::FIELD_DAY]});
    dn_hour   = $signed({4'd0, hour_q}) - $signed({8'd0, hit[cts_pkg::FIELD_HOUR]});
    dn_minute = $signed({3'd0, minute_q}) - $signed({8'd0, hit[cts_pkg::FIELD_MINUTE]});
    dn_second = $signed({3'd0, second_q}) - $signed({8'd0, hit[cts_pkg::FIELD_SECOND]});

    dn_year_n  = (dn_year < 9'sd0) ? 7'd99 : dn_year[6:0];
    dn_month_n = (dn_month < 9'sd1) ? 4'd12 : dn_month[3:0];
    dn_lim     = cts_pkg::day_limit(dn_month_n, dn_year_n[1:0]);
    if (dn_day < 9'sd1) begin
      dn_day_n = dn_lim;
    end else if (dn_day > $signed({4'd0, dn_lim})) begin
      dn_day_n = 5'd1;
    end else begin
      dn_day_n = dn_day[4:0];
    end
    dn_hour_n   = (dn_hour < 9'sd0) ? 5'd23 : dn_hour[4:0];
    dn_minute_n = (dn_minute < 9'sd0) ? 6'd59 : dn_minute[5:0];
    dn_second_n = (dn_second < 9'sd0) ? 6'd59 : dn_second[5:0];
  end

  always_comb begin
    set_mode_d  = set_mode_q;
    field_sel_d = field_sel_q;
    blink_d     = blink_q;
    tick_d      = tick_q;
    year_d      = year_q;
    month_d     = month_q;
    day_d       = day_q;
    hour_d      = hour_q;
    minute_d    = minute_q;
    second_d    = second_q;
    commit_d    = 1'b0;

    unique case (cts_pkg::cmd_e'(req_i.data.command))
      cts_pkg::CMD_TICK: begin
        if (tick_inc >= blink_ticks_q) begin
          tick_d  = 16'd0;
          blink_d = !blink_q;
        end else begin
          tick_d = tick_inc;
        end
      end
      cts_pkg::CMD_MODE: begin
        set_mode_d = !set_mode_q;
        commit_d   = set_mode_q;
      end
      cts_pkg::CMD_SELECT: begin
        if (set_mode_q) begin
          field_sel_d = (field_sel_q == cts_pkg::FIELD_SECOND) ? cts_pkg::FIELD_YEAR
                                                               : field_sel_q + 3'd1;
        end
      end
      cts_pkg::CMD_UP: begin
        if (set_mode_q) begin
          year_d   = up_year_n;
          month_d  = up_month_n;
          day_d    = up_day_n;
          hour_d   = up_hour_n;
          minute_d = up_minute_n;
          second_d = up_second_n;
        end
      end
      cts_pkg::CMD_DOWN: begin
        if (set_mode_q) begin
          year_d   = dn_year_n;
          month_d  = dn_month_n;
          day_d    = dn_day_n;
          hour_d   = dn_hour_n;
          minute_d = dn_minute_n;
          second_d = dn_second_n;
        end
      end
      cts_pkg::CMD_SAMPLE: begin
        if (!set_mode_q) begin
          year_d   = req_i.data.rtc_year;
          month_d  = req_i.data.rtc_month;
          day_d    = req_i.data.rtc_day;
          hour_d   = req_i.data.rtc_hour;
          minute_d = req_i.data.rtc_minute;
          second_d = req_i.data.rtc_second;
        end
      end
      default: begin
      end
    endcase

    rsp_d.in_set_mode    = set_mode_d;
    rsp_d.selected_field = field_sel_d;
    rsp_d.blank_selected = set_mode_d && !blink_d;
    rsp_d.year_out       = year_d;
    rsp_d.month_out      = month_d;
    rsp_d.day_out        = day_d;
    rsp_d.hour_out       = hour_d;
    rsp_d.minute_out     = minute_d;
    rsp_d.second_out     = second_d;
    rsp_d.commit         = commit_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_mode_q  <= 1'b0;
      field_sel_q <= cts_pkg::FIELD_YEAR;
      blink_q     <= 1'b0;
      tick_q      <= 16'd0;
      year_q      <= 7'd0;
      month_q     <= 4'd1;
      day_q       <= 5'd1;
      hour_q      <= 5'd0;
      minute_q    <= 6'd0;
      second_q    <= 6'd0;
    end else if (req_accept) begin
      set_mode_q  <= set_mode_d;
      field_sel_q <= field_sel_d;
      blink_q     <= blink_d;
      tick_q      <= tick_d;
      year_q      <= year_d;
      month_q     <= month_d;
      day_q       <= day_d;
      hour_q      <= hour_d;
      minute_q    <= minute_d;
      second_q    <= second_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blink_ticks_q <= cts_pkg::BLINK_TICKS_RESET;
    end else if (cfg_i.valid && cfg_i.ready) begin
      blink_ticks_q <= cfg_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      rsp_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_accept) begin
      rsp_q <= rsp_d;
    end
  end

`ifndef SYNTHESIS
  a_commit_leaves_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q && rsp_q.commit |-> !rsp_q.in_set_mode)
    else $error("commit reported while still in set mode");

  a_blank_only_in_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q && rsp_q.blank_selected |-> rsp_q.in_set_mode)
    else $error("field blanked outside set mode");

  a_field_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_accept |=> rsp_valid_q && (field_sel_q <= cts_pkg::FIELD_SECOND))
    else $error("accepted request gave no response or bad field select");

  a_mode_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_accept |=> rsp_q.in_set_mode == set_mode_q)
    else $error("reported mode differs from mode register");
`endif

endmodule
